/* hdl/cartesian_to_spherical_defines.svh */
// Assertion macros for the spherical conversion block.
// They expect clk and rst in the scope of use.
`ifndef CARTESIAN_TO_SPHERICAL_DEFINES_SVH
`define CARTESIAN_TO_SPHERICAL_DEFINES_SVH

// same-cycle implication
`define C2S_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define C2S_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/c2s_pkg.sv */
package c2s_pkg;

  // atan(2^-i) as 32-bit binary angles, 2^32 = one turn
  localparam logic [31:0] ATAN_TAB [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  // half a turn in 32-bit binary angle units
  localparam logic [31:0] ANG_PI = 32'h80000000;

endpackage

/* hdl/c2s_point_if.sv */
interface c2s_point_if #(
  parameter int COORD_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] x_coord;
  logic signed [COORD_WIDTH-1:0] y_coord;
  logic signed [COORD_WIDTH-1:0] z_coord;

  modport source (output valid, output x_coord, output y_coord, output z_coord,
                  input ready);
  modport sink (input valid, input x_coord, input y_coord, input z_coord,
                output ready);
endinterface

/* hdl/c2s_sph_if.sv */
interface c2s_sph_if #(
  parameter int COORD_WIDTH = 16,
  parameter int ANGLE_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic        [COORD_WIDTH-1:0] radius_out;
  logic        [ANGLE_WIDTH-1:0] polar_angle;
  logic signed [ANGLE_WIDTH-1:0] azimuth_angle;
  logic                          zero_vector;

  modport source (output valid, output radius_out, output polar_angle,
                  output azimuth_angle, output zero_vector, input ready);
  modport sink (input valid, input radius_out, input polar_angle,
                input azimuth_angle, input zero_vector, output ready);
endinterface

/* hdl/c2s_cordic.sv */
module c2s_cordic #(
  parameter int IW    = 34,
  parameter int NSTEP = 16
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [IW-1:0] a_in,
  input  logic signed [IW-1:0] b_in,
  input  logic        [31:0]   ang_in,
  output logic        [31:0]   ang_out
);

  logic signed [IW-1:0] a_s   [NSTEP];
  logic signed [IW-1:0] b_s   [NSTEP];
  logic        [31:0]   ang_s [NSTEP];

  for (genvar i = 0; i < NSTEP; i++) begin : g_step
    logic signed [IW-1:0] a_d;
    logic signed [IW-1:0] b_d;
    logic        [31:0]   ang_d;

    if (i == 0) begin : g_head
      assign a_d   = a_in;
      assign b_d   = b_in;
      assign ang_d = ang_in;
    end else begin : g_tail
      assign a_d   = a_s[i-1];
      assign b_d   = b_s[i-1];
      assign ang_d = ang_s[i-1];
    end

    // rotate toward b = 0; shifts floor
    always_ff @(posedge clk) begin
      if (en) begin
        if (!b_d[IW-1]) begin
          a_s[i]   <= a_d + (b_d >>> i);
          b_s[i]   <= b_d - (a_d >>> i);
          ang_s[i] <= ang_d + c2s_pkg::ATAN_TAB[i];
        end else begin
          a_s[i]   <= a_d - (b_d >>> i);
          b_s[i]   <= b_d + (a_d >>> i);
          ang_s[i] <= ang_d - c2s_pkg::ATAN_TAB[i];
        end
      end
    end
  end

  assign ang_out = ang_s[NSTEP-1];

endmodule

/* hdl/cartesian_to_spherical.sv */
// Path from input beat to result: input register, squares, sums, then the bit-per-stage
// square root of x^2 + y^2 feeding the polar-angle CORDIC, then the output register.
// Throughput: one beat per cycle; input stalls only once the output register and its skid
// entry both hold results.
// Reset (synchronous, active high) clears the stage valid bits and output valids only.
`include "cartesian_to_spherical_defines.svh"

module cartesian_to_spherical #(
  parameter int COORD_WIDTH  = 16,
  parameter int ANGLE_WIDTH  = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic      clk,
  input  logic      rst,
  c2s_point_if.sink point,
  c2s_sph_if.source sphere
);

  localparam int SCALE    = (COORD_WIDTH < 31) ? 31 - COORD_WIDTH : 0;
  localparam int QW       = COORD_WIDTH + SCALE;
  localparam int IW       = QW + 3;
  localparam int RW       = 2 * QW;
  localparam int SW       = 2 * COORD_WIDTH;
  localparam int NSTEP    = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
  localparam int P        = 3 + QW;
  localparam int LAST     = P + NSTEP;
  localparam int NREG     = LAST + 1;
  localparam int PHI_TAKE = 2 + NSTEP;

  localparam logic [ANGLE_WIDTH-1:0] ANG_HALF = {1'b1, {(ANGLE_WIDTH-1){1'b0}}};
  localparam logic [ANGLE_WIDTH-1:0] ANG_3Q   = ANG_HALF + (ANG_HALF >> 1);
  localparam logic [31:0]            ANG_RND  = (32'd1 << (32 - ANGLE_WIDTH)) >> 1;

  typedef struct packed {
    logic                          zero;
    logic                          y_zero;
    logic                          x_neg;
    logic                          xy_zero;
    logic                          z_neg;
    logic        [COORD_WIDTH-1:0] z;
    logic        [COORD_WIDTH-1:0] radius;
    logic        [31:0]            phi;
  } side_t;

  typedef struct packed {
    logic [QW+1:0] rem;
    logic [QW-1:0] root;
  } sq_t;

  typedef struct packed {
    logic [COORD_WIDTH-1:0] radius;
    logic [ANGLE_WIDTH-1:0] polar;
    logic [ANGLE_WIDTH-1:0] azimuth;
    logic                   zero;
  } res_t;

  // one restoring square-root digit
  function automatic sq_t sq_step(sq_t s, logic [1:0] pair);
    logic [QW+3:0] num;
    logic [QW+3:0] den;
    logic [QW+3:0] dif;
    sq_t           r;
    num = {s.rem, pair};
    den = {2'b00, s.root, 2'b01};
    dif = num - den;
    if (num >= den) begin
      r.rem  = dif[QW+1:0];
      r.root = {s.root[QW-2:0], 1'b1};
    end else begin
      r.rem  = num[QW+1:0];
      r.root = {s.root[QW-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic logic [ANGLE_WIDTH-1:0] to_angle(logic [31:0] u);
    logic [31:0] t;
    t = u + ANG_RND;
    return t[31 -: ANGLE_WIDTH];
  endfunction

  logic            en;
  logic [NREG-1:0] v;

  // R0
  logic signed [COORD_WIDTH-1:0] x0, y0, z0;
  // R1
  logic        [SW-1:0] sq_x, sq_y, sq_z;
  logic signed [IW-1:0] phi_a, phi_b;
  logic        [31:0]   phi_ang;
  // R2
  logic [SW-1:0] r2_sall, r2_sxy;
  // R3 .. R(2+QW)
  sq_t           sq_st  [2][QW];
  logic [RW-1:0] sq_rad [2][QW];
  logic [RW-1:0] rad_in [2];
  // R(P)
  logic signed [IW-1:0] th_a, th_b;
  logic        [31:0]   th_ang;

  side_t side [1:LAST];
  side_t side1_next;

  logic signed [2*COORD_WIDTH-1:0] px, py, pz;
  logic signed [IW-1:0]            xs, ys, zs, rho_s;
  logic signed [COORD_WIDTH-1:0]   z_p;
  logic        [31:0]              phi_cord, th_cord;

  logic [ANGLE_WIDTH-1:0] phi_r, theta_r, theta_c;
  res_t                   res_next;
  res_t                   o_res, s_res;
  logic                   o_valid, s_valid;

  assign en          = !s_valid;
  assign point.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[NREG-2:0], point.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x0 <= point.x_coord;
      y0 <= point.y_coord;
      z0 <= point.z_coord;
    end
  end

  assign px = x0 * x0;
  assign py = y0 * y0;
  assign pz = z0 * z0;
  assign xs = IW'(x0) <<< SCALE;
  assign ys = IW'(y0) <<< SCALE;

  always_ff @(posedge clk) begin
    if (en) begin
      sq_x <= px;
      sq_y <= py;
      sq_z <= pz;
      if (x0[COORD_WIDTH-1]) begin
        phi_a   <= -xs;
        phi_b   <= -ys;
        phi_ang <= c2s_pkg::ANG_PI;
      end else begin
        phi_a   <= xs;
        phi_b   <= ys;
        phi_ang <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r2_sall <= sq_x + sq_y + sq_z;
      r2_sxy  <= sq_x + sq_y;
    end
  end

  // lane 0 gives radius << SCALE, lane 1 gives rho << SCALE
  assign rad_in[0] = RW'(r2_sall) << (2 * SCALE);
  assign rad_in[1] = RW'(r2_sxy) << (2 * SCALE);

  for (genvar l = 0; l < 2; l++) begin : g_lane
    for (genvar j = 0; j < QW; j++) begin : g_digit
      sq_t           st_d;
      logic [RW-1:0] rad_d;

      if (j == 0) begin : g_head
        assign st_d  = '0;
        assign rad_d = rad_in[l];
      end else begin : g_tail
        assign st_d  = sq_st[l][j-1];
        assign rad_d = sq_rad[l][j-1];
      end

      always_ff @(posedge clk) begin
        if (en) begin
          sq_st[l][j]  <= sq_step(st_d, rad_d[RW-1-2*j -: 2]);
          sq_rad[l][j] <= rad_d;
        end
      end
    end
  end

  c2s_cordic #(
    .IW    (IW),
    .NSTEP (NSTEP)
  ) u_phi (
    .clk     (clk),
    .en      (en),
    .a_in    (phi_a),
    .b_in    (phi_b),
    .ang_in  (phi_ang),
    .ang_out (phi_cord)
  );

  // polar-angle CORDIC input: atan2(rho, z)
  assign z_p   = side[P-1].z;
  assign zs    = IW'(z_p) <<< SCALE;
  assign rho_s = {{(IW-QW){1'b0}}, sq_st[1][QW-1].root};

  always_ff @(posedge clk) begin
    if (en) begin
      if (side[P-1].z_neg) begin
        th_a   <= -zs;
        th_b   <= -rho_s;
        th_ang <= c2s_pkg::ANG_PI;
      end else begin
        th_a   <= zs;
        th_b   <= rho_s;
        th_ang <= '0;
      end
    end
  end

  c2s_cordic #(
    .IW    (IW),
    .NSTEP (NSTEP)
  ) u_theta (
    .clk     (clk),
    .en      (en),
    .a_in    (th_a),
    .b_in    (th_b),
    .ang_in  (th_ang),
    .ang_out (th_cord)
  );

  always_comb begin
    side1_next         = '0;
    side1_next.y_zero  = (y0 == '0);
    side1_next.xy_zero = (x0 == '0) && (y0 == '0);
    side1_next.zero    = (x0 == '0) && (y0 == '0) && (z0 == '0);
    side1_next.x_neg   = x0[COORD_WIDTH-1];
    side1_next.z_neg   = z0[COORD_WIDTH-1];
    side1_next.z       = z0;
  end

  for (genvar k = 1; k <= LAST; k++) begin : g_side
    if (k == 1) begin : g_head
      always_ff @(posedge clk) begin
        if (en) begin
          side[k] <= side1_next;
        end
      end
    end else begin : g_tail
      side_t side_next;

      always_comb begin
        side_next = side[k-1];
        if (k == PHI_TAKE) begin
          side_next.phi = phi_cord;
        end
        if (k == P) begin
          side_next.radius = sq_st[0][QW-1].root[QW-1 -: COORD_WIDTH];
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          side[k] <= side_next;
        end
      end
    end
  end

  assign phi_r   = to_angle(side[LAST].phi);
  assign theta_r = to_angle(th_cord);

  always_comb begin
    theta_c = theta_r;
    if (theta_r > ANG_HALF) begin
      theta_c = (theta_r >= ANG_3Q) ? '0 : ANG_HALF;
    end
    res_next.radius  = side[LAST].radius;
    res_next.polar   = side[LAST].xy_zero ? (side[LAST].z_neg ? ANG_HALF : '0) : theta_c;
    res_next.azimuth = side[LAST].y_zero ? (side[LAST].x_neg ? ANG_HALF : '0) : phi_r;
    res_next.zero    = 1'b0;
    if (side[LAST].zero) begin
      res_next      = '0;
      res_next.zero = 1'b1;
    end
  end

  // output register plus one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      s_valid <= 1'b0;
    end else if (s_valid) begin
      if (sphere.ready) begin
        s_valid <= 1'b0;
      end
    end else if (v[LAST]) begin
      if (!o_valid || sphere.ready) begin
        o_valid <= 1'b1;
      end else begin
        s_valid <= 1'b1;
      end
    end else if (sphere.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid) begin
      if (sphere.ready) begin
        o_res <= s_res;
      end
    end else if (v[LAST]) begin
      if (!o_valid || sphere.ready) begin
        o_res <= res_next;
      end else begin
        s_res <= res_next;
      end
    end
  end

  assign sphere.valid         = o_valid;
  assign sphere.radius_out    = o_res.radius;
  assign sphere.polar_angle   = o_res.polar;
  assign sphere.azimuth_angle = o_res.azimuth;
  assign sphere.zero_vector   = o_res.zero;

  `C2S_ASSERT(a_skid_under_out, s_valid, sphere.valid, "skid beat without output beat")
  `C2S_ASSERT_NEXT(a_skid_hold, s_valid && !sphere.ready, s_valid && $stable(s_res),
                   "skid beat changed while stalled")
  `C2S_ASSERT(a_origin_zero, sphere.valid && sphere.zero_vector,
              sphere.radius_out == '0 && sphere.polar_angle == '0 &&
              sphere.azimuth_angle == '0, "origin beat with nonzero fields")
  `C2S_ASSERT(a_polar_range, sphere.valid, sphere.polar_angle <= ANG_HALF,
              "polar angle beyond half turn")

endmodule
